FILE: hw/rtl/pst_pkg.sv
package pst_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_SERVE
    } pst_state_t;

endpackage

FILE: hw/rtl/priority_scheduler_tick.sv
// Priority scheduler, one command per time tick.
//
// A tick is transferred at a rising edge with start high and busy low. It may
// carry one job arrival (arrive_valid, arrive_priority, arrive_burst). Jobs get
// ids 1, 2, 3, ... in arrival order. The block retires a finished runner,
// registers the arrival (which may pre-empt the runner when preemptive is set),
// picks the best waiting job when idle, and serves one tick of it.
//
// Exactly one result per tick is shown for one cycle with result_valid high.
// The receiver cannot stall it. A tick that keeps its runner passes through
// ST_EVAL and ST_SERVE. When no runner is left it scans the job table, all
// jobs arrived so far, one slot per cycle over the single read port of the
// job memory, before it serves the tick.
// busy falls in the cycle the result is shown, so the next tick can be
// transferred in that same cycle.
//
// Reset clears time, the running job, the job count and all waiting flags and
// sets preemptive to 1. The job memory needs no clearing: a slot is written at
// its job's arrival before it is ever read. cfg_we writes preemptive.
module priority_scheduler_tick #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16,
    parameter int PRIO_BITS = 8,
    localparam int IdW   = $clog2(MAX_JOBS + 1),
    localparam int SlotW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 arrive_valid,
    input  logic [PRIO_BITS-1:0] arrive_priority,
    input  logic [TIME_BITS-1:0] arrive_burst,
    output logic                 result_valid,
    output logic [TIME_BITS-1:0] tick_time,
    output logic [IdW-1:0]       run_id,
    output logic                 first_run,
    output logic                 done_valid,
    output logic [IdW-1:0]       done_id,
    output logic [TIME_BITS-1:0] done_turnaround,
    output logic [TIME_BITS-1:0] done_waiting,
    output logic                 arrival_dropped
);
    import pst_pkg::*;

    typedef struct packed {
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] orig;
        logic [PRIO_BITS-1:0] prio;
        logic [TIME_BITS-1:0] stamp;
    } job_row_t;

    job_row_t job_mem [MAX_JOBS];

    pst_state_t state_reg, state_next;

    logic                 preempt_reg;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [IdW-1:0]       running_reg, running_next;
    logic [IdW-1:0]       count_reg, count_next;
    logic [MAX_JOBS-1:0]  waiting_reg, waiting_next;

    logic                 in_valid_reg;
    logic [PRIO_BITS-1:0] in_prio_reg;
    logic [TIME_BITS-1:0] in_burst_reg;

    job_row_t             cur_row_reg, cur_row_next;
    job_row_t             best_row_reg, best_row_next;
    logic [IdW-1:0]       best_reg, best_next;
    logic [IdW-1:0]       scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [SlotW-1:0]     cmp_idx_reg, cmp_idx_next;

    logic                 dvalid_reg, dvalid_next;
    logic [IdW-1:0]       did_reg, did_next;
    logic [TIME_BITS-1:0] dturn_reg, dturn_next;
    logic [TIME_BITS-1:0] dorig_reg, dorig_next;
    logic                 dropped_reg, dropped_next;

    logic                 res_valid_reg, res_valid_next;
    logic [TIME_BITS-1:0] res_time_reg, res_time_next;
    logic [IdW-1:0]       res_run_reg, res_run_next;
    logic                 res_first_reg, res_first_next;
    logic                 res_dvalid_reg, res_dvalid_next;
    logic [IdW-1:0]       res_did_reg, res_did_next;
    logic [TIME_BITS-1:0] res_turn_reg, res_turn_next;
    logic [TIME_BITS-1:0] res_wait_reg, res_wait_next;
    logic                 res_drop_reg, res_drop_next;

    logic [SlotW-1:0]     rd_addr;
    job_row_t             rd_data_reg;
    logic                 wr_en;
    logic [SlotW-1:0]     wr_addr;
    job_row_t             wr_data;

    logic                 accept;
    logic [IdW-1:0]       run_slot_id;
    logic [SlotW-1:0]     run_slot;

    assign accept      = start && (state_reg == ST_IDLE);
    assign busy        = (state_reg != ST_IDLE);
    assign run_slot_id = running_reg - IdW'(1);
    assign run_slot    = run_slot_id[SlotW-1:0];

    // Job memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            job_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= job_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            preempt_reg   <= 1'b1;
            now_reg       <= '0;
            running_reg   <= '0;
            count_reg     <= '0;
            waiting_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            waiting_reg   <= waiting_next;
            cmp_valid_reg <= cmp_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                preempt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_valid_reg <= arrive_valid;
            in_prio_reg  <= arrive_priority;
            in_burst_reg <= arrive_burst;
        end
        cur_row_reg    <= cur_row_next;
        best_row_reg   <= best_row_next;
        best_reg       <= best_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        dvalid_reg     <= dvalid_next;
        did_reg        <= did_next;
        dturn_reg      <= dturn_next;
        dorig_reg      <= dorig_next;
        dropped_reg    <= dropped_next;
        res_time_reg   <= res_time_next;
        res_run_reg    <= res_run_next;
        res_first_reg  <= res_first_next;
        res_dvalid_reg <= res_dvalid_next;
        res_did_reg    <= res_did_next;
        res_turn_reg   <= res_turn_next;
        res_wait_reg   <= res_wait_next;
        res_drop_reg   <= res_drop_next;
    end

    always_comb
    begin
        logic [IdW-1:0]       run;
        logic [IdW-1:0]       new_id;
        logic [SlotW-1:0]     new_slot;
        logic [SlotW-1:0]     sel_slot;
        logic [IdW-1:0]       sel_id;
        job_row_t             new_row;
        job_row_t             served;

        state_next     = state_reg;
        now_next       = now_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        waiting_next   = waiting_reg;
        cur_row_next   = cur_row_reg;
        best_row_next  = best_row_reg;
        best_next      = best_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        dvalid_next    = dvalid_reg;
        did_next       = did_reg;
        dturn_next     = dturn_reg;
        dorig_next     = dorig_reg;
        dropped_next   = dropped_reg;

        res_valid_next  = 1'b0;
        res_time_next   = res_time_reg;
        res_run_next    = res_run_reg;
        res_first_next  = res_first_reg;
        res_dvalid_next = res_dvalid_reg;
        res_did_next    = res_did_reg;
        res_turn_next   = res_turn_reg;
        res_wait_next   = res_wait_reg;
        res_drop_next   = res_drop_reg;

        rd_addr = run_slot;
        wr_en   = 1'b0;
        wr_addr = run_slot;
        wr_data = cur_row_reg;

        run      = running_reg;
        new_id   = count_reg + IdW'(1);
        new_slot = count_reg[SlotW-1:0];
        sel_slot = '0;
        sel_id   = '0;
        new_row  = '{rem: in_burst_reg, orig: in_burst_reg, prio: in_prio_reg,
                     stamp: now_reg};
        served   = cur_row_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // The runner's row is read at the transfer edge.
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                cur_row_next = rd_data_reg;
                dvalid_next  = 1'b0;
                did_next     = '0;
                dturn_next   = '0;
                dorig_next   = '0;
                dropped_next = 1'b0;
                if (run != '0 && rd_data_reg.rem == '0)
                begin
                    dvalid_next            = 1'b1;
                    did_next               = run;
                    dturn_next             = now_reg - rd_data_reg.stamp;
                    dorig_next             = rd_data_reg.orig;
                    waiting_next[run_slot] = 1'b0;
                    run                    = '0;
                end
                if (in_valid_reg)
                begin
                    if (count_reg < IdW'(MAX_JOBS))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = new_slot;
                        wr_data    = new_row;
                        count_next = new_id;
                        if (preempt_reg && run != '0 && in_prio_reg < rd_data_reg.prio)
                        begin
                            waiting_next[run_slot] = 1'b1;
                            waiting_next[new_slot] = 1'b0;
                            run                    = new_id;
                            cur_row_next           = new_row;
                        end
                        else
                        begin
                            waiting_next[new_slot] = 1'b1;
                        end
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                running_next = run;
                if (run == '0)
                begin
                    scan_idx_next = '0;
                    best_next     = '0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    state_next = ST_SERVE;
                end
            end

            ST_SCAN:
            begin
                // Reads are issued one slot per cycle; each row is compared
                // in the cycle after its read.
                if (scan_idx_reg < count_reg)
                begin
                    rd_addr        = scan_idx_reg[SlotW-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[SlotW-1:0];
                    scan_idx_next  = scan_idx_reg + IdW'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (waiting_reg[cmp_idx_reg] &&
                        (best_reg == '0 || rd_data_reg.prio < best_row_reg.prio))
                    begin
                        best_next     = IdW'(cmp_idx_reg) + IdW'(1);
                        best_row_next = rd_data_reg;
                    end
                end
                else if (scan_idx_reg >= count_reg)
                begin
                    running_next = best_reg;
                    cur_row_next = best_row_reg;
                    sel_id       = best_reg - IdW'(1);
                    sel_slot     = sel_id[SlotW-1:0];
                    if (best_reg != '0)
                    begin
                        waiting_next[sel_slot] = 1'b0;
                    end
                    state_next = ST_SERVE;
                end
            end

            ST_SERVE:
            begin
                res_first_next = 1'b0;
                if (run != '0)
                begin
                    res_first_next = (cur_row_reg.rem == cur_row_reg.orig);
                    if (cur_row_reg.rem != '0)
                    begin
                        served.rem = cur_row_reg.rem - TIME_BITS'(1);
                    end
                    wr_en   = 1'b1;
                    wr_addr = run_slot;
                    wr_data = served;
                end
                res_valid_next  = 1'b1;
                res_time_next   = now_reg;
                res_run_next    = run;
                res_dvalid_next = dvalid_reg;
                res_did_next    = did_reg;
                res_turn_next   = dturn_reg;
                res_wait_next   = dturn_reg - dorig_reg;
                res_drop_next   = dropped_reg;
                now_next        = now_reg + TIME_BITS'(1);
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid    = res_valid_reg;
    assign tick_time       = res_time_reg;
    assign run_id          = res_run_reg;
    assign first_run       = res_first_reg;
    assign done_valid      = res_dvalid_reg;
    assign done_id         = res_did_reg;
    assign done_turnaround = res_turn_reg;
    assign done_waiting    = res_wait_reg;
    assign arrival_dropped = res_drop_reg;

endmodule

FILE: hw/rtl/pst_checker.sv
module pst_checker #(
    parameter int MAX_JOBS  = 16,
    parameter int TIME_BITS = 16,
    localparam int IdW = $clog2(MAX_JOBS + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 result_valid,
    input logic [IdW-1:0]       run_id,
    input logic                 first_run,
    input logic                 done_valid,
    input logic [IdW-1:0]       done_id,
    input logic [TIME_BITS-1:0] done_turnaround
);

    // A transferred tick keeps the block busy until its result is shown.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("tick transfer did not raise busy");

    // The result appears only once the block has finished the tick.
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && !$past(result_valid))
        else $error("result shown while busy or twice in a row");

    a_ids_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> run_id <= IdW'(MAX_JOBS) && done_id <= IdW'(MAX_JOBS))
        else $error("job id out of range");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (done_valid && done_id != '0) ||
                         (!done_valid && done_id == '0 && done_turnaround == '0))
        else $error("completion fields inconsistent");

    a_idle_first: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && run_id == '0 |-> !first_run)
        else $error("first_run set while idle");

endmodule

bind priority_scheduler_tick pst_checker #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
) u_pst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .result_valid    (result_valid),
    .run_id          (run_id),
    .first_run       (first_run),
    .done_valid      (done_valid),
    .done_id         (done_id),
    .done_turnaround (done_turnaround)
);

FILE: bench/priority_scheduler_tick_test.sv
`timescale 1ns / 100ps

module priority_scheduler_tick_test;

    localparam int MAX_JOBS    = 16;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [15:0] tick_time;
        logic [4:0]  run_id;
        logic        first_run;
        logic        done_valid;
        logic [4:0]  done_id;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        dropped;
    } tick_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        arrive_valid = 1'b0;
    logic [7:0]  arrive_priority = '0;
    logic [15:0] arrive_burst = '0;
    logic        result_valid;
    logic [15:0] tick_time;
    logic [4:0]  run_id;
    logic        first_run;
    logic        done_valid;
    logic [4:0]  done_id;
    logic [15:0] done_turnaround;
    logic [15:0] done_waiting;
    logic        arrival_dropped;

    // Scheduler state as the testbench sees it.
    bit          preempt_on;
    logic [15:0] sim_now;
    logic [4:0]  cur_job;
    int          job_total;
    bit          queued [MAX_JOBS];
    logic [15:0] left_burst [MAX_JOBS];
    logic [15:0] full_burst [MAX_JOBS];
    logic [7:0]  job_prio [MAX_JOBS];
    logic [15:0] stamp [MAX_JOBS];

    tick_report_t expected_ticks [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    priority_scheduler_tick DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .start           (start),
        .busy            (busy),
        .arrive_valid    (arrive_valid),
        .arrive_priority (arrive_priority),
        .arrive_burst    (arrive_burst),
        .result_valid    (result_valid),
        .tick_time       (tick_time),
        .run_id          (run_id),
        .first_run       (first_run),
        .done_valid      (done_valid),
        .done_id         (done_id),
        .done_turnaround (done_turnaround),
        .done_waiting    (done_waiting),
        .arrival_dropped (arrival_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic tick_report_t schedule_tick(input logic av, input logic [7:0] pr,
                                                   input logic [15:0] bu);
        tick_report_t r;
        int          slot;
        logic [4:0]  best;
        logic [7:0]  best_prio;
        r = '{default: '0};
        r.tick_time = sim_now;
        if (cur_job != 0 && left_burst[cur_job - 1] == 0)
        begin
            slot = cur_job - 1;
            r.done_valid = 1'b1;
            r.done_id    = cur_job;
            r.turnaround = sim_now - stamp[slot];
            r.waiting    = r.turnaround - full_burst[slot];
            queued[slot] = 1'b0;
            cur_job      = '0;
        end
        if (av)
        begin
            if (job_total < MAX_JOBS)
            begin
                slot             = job_total;
                left_burst[slot] = bu;
                full_burst[slot] = bu;
                job_prio[slot]   = pr;
                stamp[slot]      = sim_now;
                queued[slot]     = 1'b1;
                job_total++;
                if (preempt_on && cur_job != 0 && pr < job_prio[cur_job - 1])
                begin
                    queued[cur_job - 1] = 1'b1;
                    queued[slot]        = 1'b0;
                    cur_job             = 5'(slot + 1);
                end
            end
            else
            begin
                r.dropped = 1'b1;
            end
        end
        if (cur_job == 0)
        begin
            best      = '0;
            best_prio = '0;
            for (int i = 0; i < job_total; i++)
            begin
                if (queued[i] && (best == 0 || job_prio[i] < best_prio))
                begin
                    best      = 5'(i + 1);
                    best_prio = job_prio[i];
                end
            end
            cur_job = best;
            if (cur_job != 0)
                queued[cur_job - 1] = 1'b0;
        end
        if (cur_job != 0)
        begin
            slot        = cur_job - 1;
            r.first_run = (left_burst[slot] == full_burst[slot]);
            if (left_burst[slot] != 0)
                left_burst[slot]--;
        end
        r.run_id = cur_job;
        sim_now++;
        return r;
    endfunction

    function automatic bit scheduler_empty();
        bit any;
        any = (cur_job != 0);
        for (int i = 0; i < job_total; i++)
            any |= queued[i];
        return !any;
    endfunction

    // Drives one tick and holds it until the block takes it.
    task automatic send_tick(input logic av, input logic [7:0] pr, input logic [15:0] bu);
        @(negedge clk);
        start           <= 1'b1;
        arrive_valid    <= av;
        arrive_priority <= pr;
        arrive_burst    <= bu;
        do
            @(posedge clk);
        while (busy);
        expected_ticks.push_back(schedule_tick(av, pr, bu));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_preemptive(input bit v);
        wait_all_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        preempt_on = v;
    endtask

    task automatic sender_gap();
        int n;
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            n = 0;
        else if (r < 9)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(15, 60);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic run_until_empty();
        while (!scheduler_empty())
            send_tick(1'b0, 8'($urandom), 16'($urandom));
        send_tick(1'b0, 8'($urandom), 16'($urandom));
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_empty_queue();
        write_preemptive(1'b1);
        send_tick(1'b0, 8'hFF, 16'hFFFF);
        send_tick(1'b0, 8'h00, 16'h0000);
        send_tick(1'b0, 8'($urandom), 16'($urandom));
    endtask

    task automatic test_preemption();
        send_tick(1'b1, 8'd200, 16'd3);
        // Same priority number as the runner: it has to wait.
        send_tick(1'b1, 8'd200, 16'd2);
        // Best priority with zero burst takes over and runs for a single tick.
        send_tick(1'b1, 8'd0, 16'd0);
        run_until_empty();
    endtask

    task automatic test_no_preemption();
        write_preemptive(1'b0);
        send_tick(1'b1, 8'd255, 16'd4);
        send_tick(1'b1, 8'd1, 16'd1);
        // Tie on priority; the lower id must be picked first.
        send_tick(1'b1, 8'd1, 16'd2);
        run_until_empty();
    endtask

    task automatic test_random_mix(input bit mode, input int job_cap, input int count);
        logic       av;
        logic [7:0] pr;
        logic [15:0] bu;
        int         r;
        write_preemptive(mode);
        repeat (count)
        begin
            av = (job_total < job_cap) && ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       pr = 8'd0;
                    1:       pr = 8'd7;
                    default: pr = 8'd255;
                endcase
            end
            else
            begin
                pr = 8'($urandom_range(0, 255));
            end
            r = $urandom_range(0, 9);
            if (!av)
                bu = 16'($urandom);
            else if (r == 0)
                bu = 16'd0;
            else if (r < 8)
                bu = 16'($urandom_range(1, 6));
            else if (r == 8)
                bu = 16'($urandom_range(7, 40));
            else
                bu = 16'($urandom_range(41, 200));
            send_tick(av, pr, bu);
            if ($urandom_range(0, 59) == 0)
                wait_all_results();
            else
                sender_gap();
        end
    endtask

    // The table fills up, so every later arrival must be dropped.
    task automatic test_full_table();
        write_preemptive(1'b1);
        while (job_total < MAX_JOBS - 2)
            send_tick(1'b1, 8'($urandom), 16'($urandom_range(1, 4)));
        send_tick(1'b1, 8'd0, 16'd12);
        send_tick(1'b1, 8'd255, 16'd5);
        repeat (4)
        begin
            send_tick(1'b1, 8'($urandom), 16'($urandom));
            sender_gap();
        end
        run_until_empty();
        send_tick(1'b1, 8'd0, 16'd1);
        send_tick(1'b0, 8'($urandom), 16'($urandom));
    endtask

    always @(posedge clk)
    begin : result_check
        tick_report_t want;
        if ((start && !busy) || result_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && result_valid)
        begin
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: result with none expected, tick_time %0d", $time, tick_time);
                mismatch_count++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                compare_field("tick_time", want.tick_time, tick_time);
                compare_field("run_id", 16'(want.run_id), 16'(run_id));
                compare_field("first_run", 16'(want.first_run), 16'(first_run));
                compare_field("done_valid", 16'(want.done_valid), 16'(done_valid));
                compare_field("done_id", 16'(want.done_id), 16'(done_id));
                compare_field("done_turnaround", want.turnaround, done_turnaround);
                compare_field("done_waiting", want.waiting, done_waiting);
                compare_field("arrival_dropped", 16'(want.dropped), 16'(arrival_dropped));
            end
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        preempt_on     = 1'b1;
        sim_now        = '0;
        cur_job        = '0;
        job_total      = 0;
        foreach (queued[i])
            queued[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_preemption();
        test_no_preemption();
        test_random_mix(1'b0, 10, 160);
        test_random_mix(1'b1, MAX_JOBS - 2, 160);
        test_full_table();

        wait_all_results();
        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pst_pkg.sv
hw/rtl/priority_scheduler_tick.sv
hw/rtl/pst_checker.sv
bench/priority_scheduler_tick_test.sv
